// ===== hw/rtl/tdf_pkg.sv =====
// Shared types and constants for the trial-division factorizer.
package tdf_pkg;

    // Fixed widths of the transfer payload fields
    localparam int FIELD_W = 32;

    // Default width of the arithmetic datapath
    localparam int VALUE_WIDTH_DEF = 32;

    // First trial divisor and smallest value that has a factorization
    localparam int FIRST_DIVISOR = 2;

endpackage : tdf_pkg

// ===== hw/rtl/tdf_if.sv =====
// Valid/ready channel interfaces for the factorizer input and result streams.
interface tdf_in_if;
    import tdf_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface : tdf_in_if

interface tdf_out_if;
    import tdf_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] factor;
    logic               no_factorization;
    logic               is_last;

    modport source (output valid, output factor, output no_factorization,
                    output is_last, input ready);
    modport sink   (input valid, input factor, input no_factorization,
                    input is_last, output ready);
endinterface : tdf_out_if

// ===== hw/rtl/trial_division_factorizer_core.sv =====
// Top level of the trial-division prime factorizer.
//
// Takes one unsigned number per input transfer and returns its prime factors in
// ascending order, repeats included, one result transfer per factor; the last
// result of a run carries is_last. A number below 2 gives a single result with
// factor 0, no_factorization and is_last set. Only the low VALUE_WIDTH bits of
// the number are used. The input is not ready while a run is in progress.
// Timing: a number is taken in an idle cycle and checked in the following start
// cycle; a number below 2 is answered from the start state once the output
// register is free. Otherwise each trial is one division in the shared bit-serial
// divider: the sequencer waits in the divide state until the divider is done,
// decides in the check state, and that deciding cycle launches the next trial unless
// the run ends or an emit stalls. A number N costs roughly (p_max + f) trials, where
// p_max is the largest divisor tried (about the square root of the remaining value)
// and f the number of factors, so a 32-bit prime costs about 65536 trials. Results
// wait in a one-deep output register; a stalled sink holds the sequencer at its
// next emit.
module trial_division_factorizer_core #(
    parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tdf_in_if.sink    i_in,
    tdf_out_if.source o_out
);
    import tdf_pkg::*;

    localparam int W = VALUE_WIDTH;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,   // waiting for a number
        ST_START = 4'b0010,   // small-value check, launch first trial
        ST_DIV   = 4'b0100,   // divider running
        ST_CHECK = 4'b1000    // act on quotient and remainder
    } t_state;

    t_state r_state, n_state;

    // Value still to factor and the current trial divisor
    logic [W-1:0] r_rem, n_rem;
    logic [W-1:0] r_dvs, n_dvs;

    // Output holding register
    logic               r_out_valid, n_out_valid;
    logic [FIELD_W-1:0] r_factor, n_factor;
    logic               r_nofac, n_nofac;
    logic               r_last, n_last;

    logic         slot_free;
    logic         div_start;
    logic         div_done;
    logic [W-1:0] div_quo;
    logic [W-1:0] div_rmd;

    // Width adaptation between payload fields and the datapath
    logic [W+FIELD_W-1:0] in_wide;
    logic [W-1:0]         in_value;
    logic [W+FIELD_W-1:0] rem_wide;
    logic [W+FIELD_W-1:0] dvs_wide;

    assign in_wide  = {{W{1'b0}}, i_in.number};
    assign in_value = in_wide[W-1:0];
    assign rem_wide = {{FIELD_W{1'b0}}, r_rem};
    assign dvs_wide = {{FIELD_W{1'b0}}, r_dvs};

    // A result can be written when the register is empty or drains this cycle
    assign slot_free = !r_out_valid || o_out.ready;

    tdf_div #(
        .W (W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (n_rem),
        .i_divisor   (n_dvs),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rmd)
    );

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_out_valid = r_out_valid && !o_out.ready;
        n_factor    = r_factor;
        n_nofac     = r_nofac;
        n_last      = r_last;
        div_start   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_rem   = in_value;
                    n_dvs   = W'(FIRST_DIVISOR);
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (r_rem < W'(FIRST_DIVISOR)) begin
                    // zero or one: single flagged result
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_factor    = '0;
                        n_nofac     = 1'b1;
                        n_last      = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_dvs > div_quo) begin
                    // divisor squared exceeds remainder: what is left is prime
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_factor    = rem_wide[FIELD_W-1:0];
                        n_nofac     = 1'b0;
                        n_last      = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else if (div_rmd == '0) begin
                    // divides evenly: emit divisor, keep trying it
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_factor    = dvs_wide[FIELD_W-1:0];
                        n_nofac     = 1'b0;
                        n_last      = 1'b0;
                        n_rem       = div_quo;
                        div_start   = 1'b1;
                        n_state     = ST_DIV;
                    end
                end else begin
                    n_dvs     = r_dvs + W'(1);
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rem       <= '0;
            r_dvs       <= W'(FIRST_DIVISOR);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rem       <= n_rem;
            r_dvs       <= n_dvs;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_factor <= n_factor;
        r_nofac  <= n_nofac;
        r_last   <= n_last;
    end

    assign i_in.ready             = (r_state == ST_IDLE);
    assign o_out.valid            = r_out_valid;
    assign o_out.factor           = r_factor;
    assign o_out.no_factorization = r_nofac;
    assign o_out.is_last          = r_last;

`ifndef SYNTH
    // A flagged result is always a lone, zero-valued, last result
    a_nofac_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.no_factorization) |-> (o_out.factor == '0 && o_out.is_last))
        else $error("no_factorization result malformed");

    // An accepted number always starts a run
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ST_START))
        else $error("accepted transfer did not start a run");

    // Trial divisor never drops below two
    a_dvs_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dvs >= W'(FIRST_DIVISOR))
        else $error("trial divisor below two");

    // The divider only finishes while the sequencer waits on it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");
`endif

endmodule : trial_division_factorizer_core

// ===== hw/rtl/tdf_div.sv =====
// Restoring bit-serial divider: one quotient bit per cycle.
module tdf_div #(
    parameter int W = tdf_pkg::VALUE_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);
    import tdf_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic             r_run;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_dvs;

    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic             ge;

    // Bring down the next dividend bit, try the subtraction
    assign shifted = {r_rem, r_quo[W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign ge      = (shifted >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= CNT_W'(W);
        end else if (r_run && (r_cnt == '0)) begin
            r_run <= 1'b0;
        end else if (r_run) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_run && (r_cnt != '0)) begin
            r_rem <= ge ? diff[W-1:0] : shifted[W-1:0];
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    assign o_done      = r_run && (r_cnt == '0);
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule : tdf_div

// ===== tb/trial_division_factorizer_core_tb.sv =====
// Testbench for the trial-division factorizer: directed and random numbers, scoreboard on factor runs.

class factor_ledger;
    typedef struct packed {
        logic [tdf_pkg::FIELD_W-1:0] factor;
        logic                        no_fact;
        logic                        last;
    } t_factor_res;

    t_factor_res owed_factors[$];
    int unsigned failures;

    function new();
        failures = 0;
    endfunction

    function int unsigned pending();
        return owed_factors.size();
    endfunction

    function void owe(longint unsigned factor, bit no_fact, bit last);
        t_factor_res r;
        r.factor  = factor[tdf_pkg::FIELD_W-1:0];
        r.no_fact = no_fact;
        r.last    = last;
        owed_factors.insert(owed_factors.size(), r);
    endfunction

    // Queue the prime factors of one accepted number, smallest first.
    function void note_number(logic [tdf_pkg::FIELD_W-1:0] number);
        longint unsigned value_mask;
        longint unsigned rest;
        longint unsigned div;
        value_mask = {64{1'b1}} >> (64 - tdf_pkg::VALUE_WIDTH_DEF);
        rest = longint'(number) & value_mask;
        if (rest < tdf_pkg::FIRST_DIVISOR) begin
            owe(0, 1'b1, 1'b1);
            return;
        end
        div = tdf_pkg::FIRST_DIVISOR;
        while (div <= rest / div) begin
            if (rest % div == 0) begin
                rest = rest / div;
                owe(div, 1'b0, 1'b0);
            end else begin
                div++;
            end
        end
        // whatever is left is prime and closes the run
        owe(rest, 1'b0, 1'b1);
    endfunction

    function void check_factor(logic [tdf_pkg::FIELD_W-1:0] factor, logic no_fact,
                               logic last);
        t_factor_res want;
        if (owed_factors.size() == 0) begin
            if (failures < 10)
                $display("ERROR: unexpected result factor=%0d nofac=%b last=%b",
                         factor, no_fact, last);
            failures++;
            return;
        end
        want = owed_factors.pop_front();
        if (factor !== want.factor || no_fact !== want.no_fact || last !== want.last) begin
            if (failures < 10)
                $display("ERROR: factor=%0d nofac=%b last=%b, expected %0d/%b/%b",
                         factor, no_fact, last, want.factor, want.no_fact, want.last);
            failures++;
        end
    endfunction
endclass

module trial_division_factorizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdf_pkg::*;

    // Slowest directed number needs at most about 7300 trials; random
    // numbers are built to stay near 130 trials. The limit is many times a correct run.
    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    localparam int unsigned RANDOM_COUNT = 80;
    localparam int unsigned CALM_FROM    = 64;   // last random items run without idling
    localparam int unsigned HOLD_AFTER   = 80;   // results taken before the long sink hold
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned TAIL_CYCLES  = 200;  // quiet stretch after the drain

    // Directed numbers: no-factorization inputs, small primes and squares, the
    // longest factor runs (2^31, 3 * 2^30), all-ones and alternating patterns, a few mid-size primes.
    localparam int CORNER_COUNT = 21;
    localparam logic [FIELD_W-1:0] CORNER_NUMBERS [CORNER_COUNT] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd9, 32'd12, 32'd49, 32'd63001,
        32'd65536, 32'd65521, 32'd1000003, 32'd223092870, 32'd53471161,
        32'h8000_0000, 32'hC000_0000, 32'hFFFF_0000, 32'h5555_5555,
        32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h0000_0001
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tdf_in_if  in_ch();
    tdf_out_if out_ch();

    trial_division_factorizer_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    factor_ledger ledger = new();

    bit          calm   = 1'b0;   // set for the closing stretch: no idling on either side
    int unsigned cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Both channels are observed from one process so that a number is always
    // noted before any result it causes is checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                ledger.note_number(in_ch.number);
            if (out_ch.valid && out_ch.ready)
                ledger.check_factor(out_ch.factor, out_ch.no_factorization, out_ch.is_last);
        end
    end

    // Result sink: random stall bursts, plus one long hold once enough results have
    // gone by. During the hold the block fills its output register, stalls at its next
    // emit and takes no numbers while the sender keeps offering.
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned taken;
        bit          held;
        stall_left = 0;
        taken      = 0;
        held       = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready && i_rst_n)
                taken++;
            if (stall_left > 0)
                stall_left--;
            else if (!held && taken >= HOLD_AFTER) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (!calm && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 12);
            out_ch.ready <= (stall_left == 0) && i_rst_n;
        end
    end

    // Sender gap: valid low, junk on the number lines.
    task automatic pause_sender(input int unsigned gap);
        in_ch.valid  <= 1'b0;
        in_ch.number <= $urandom();
        repeat (gap) @(posedge i_clk);
    endtask

    // Offer one number and hold it until the transfer happens.
    task automatic send_number(input logic [FIELD_W-1:0] number);
        if (!calm && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 12));
        in_ch.valid  <= 1'b1;
        in_ch.number <= number;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // One edge first so the last accepted number is already noted.
    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (ledger.pending() != 0);
    endtask

    // Random numbers whose largest trial divisor stays near 100: products of small
    // factors, optionally with a cofactor up to 10000 (whose primes end the trials at
    // its square root), or a number below 1001 as it is.
    function automatic logic [FIELD_W-1:0] pick_number();
        longint unsigned n;
        longint unsigned f;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1);
            1: return $urandom_range(2, 1000);
            2, 3: n = $urandom_range(2, 10000);
            default: n = 1;
        endcase
        repeat ($urandom_range(1, 40)) begin
            f = $urandom_range(2, 97);
            if (n * f <= 64'hFFFF_FFFF)
                n = n * f;
        end
        if (n < 2)
            n = $urandom_range(2, 97);
        return n[FIELD_W-1:0];
    endfunction

    initial begin : stimulus
        in_ch.valid  = 1'b0;
        in_ch.number = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (CORNER_NUMBERS[k])
            send_number(CORNER_NUMBERS[k]);

        // Let every owed result come back before the random part.
        wait_for_drain();

        for (int unsigned k = 0; k < RANDOM_COUNT; k++) begin
            calm = (k >= CALM_FROM);
            send_number(pick_number());
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (ledger.failures == 0 && ledger.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule : trial_division_factorizer_core_tb
